FILE: rtl/uwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the utilization window monitor.
// Used by uwm_div and utilization_window_monitor; depends on nothing.
package uwm_pkg;

  localparam int TICK_W      = 64;
  localparam int PERCENT_W   = 15;
  localparam int SAMPLE_W    = 3;
  localparam int FILL_OUT_W  = 9;
  localparam int VALID_OUT_W = 3;
  localparam int FULL_SCALE  = 25600;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_TARGET = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_LIMIT     = 1'd1;

  localparam logic [SAMPLE_W-1:0]  INTERVAL_TARGET_RESET = 3'd3;
  localparam logic [PERCENT_W-1:0] SPIKE_LIMIT_RESET     = 15'd24320;

  localparam int DIV_W      = 64;
  localparam int DIV_STEP_W = 6;

  localparam int RATIO_W = 16;
  localparam logic [DIV_STEP_W-1:0] RATIO_STEPS = 6'd16;
  localparam logic [RATIO_W-1:0]    RATIO_SAT   = 16'hFFFF;

  typedef struct packed {
    logic [TICK_W-1:0] total_ticks;
    logic [TICK_W-1:0] idle_ticks;
  } snapshot_t;

  typedef struct packed {
    logic [PERCENT_W-1:0]   current_percent;
    logic [PERCENT_W-1:0]   average_percent;
    logic [PERCENT_W-1:0]   peak_percent;
    logic [FILL_OUT_W-1:0]  window_fill;
    logic [VALID_OUT_W-1:0] valid_intervals;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_W-1:0]      divisor;
    logic [DIV_W-1:0]      rem_init;
    logic [DIV_W-1:0]      dividend;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic             rem_nz;
  } div_rsp_t;

endpackage

FILE: rtl/uwm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module uwm_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/uwm_div.sv
`timescale 1ns / 1ps
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on uwm_pkg for the request and response structs.
module uwm_div
  import uwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      quo;
  logic [DIV_W-1:0]      dsr;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [DIV_W-1:0] rem_step;

  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    diff     = trial - {1'b0, dsr};
    fits     = trial >= {1'b0, dsr};
    rem_step = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_step;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;
  assign rsp.rem_nz   = (rem != '0);

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with no steps left");

endmodule

FILE: rtl/utilization_window_monitor.sv
`timescale 1ns / 1ps
// Utilization window monitor: turns snapshots of cumulative total and idle tick
// counters into busy percent (unsigned Q7.8) per measurement, with a history window.
// Depends on uwm_pkg, uwm_div and uwm_ram.
//
// Usage:
//   snap channel (snap_valid / snap_stall / snap) takes one snapshot per item.
//   A measurement is one baseline item followed by interval_target items, at least
//   one; the item that closes it yields one item on the result channel, the others none.
//   cfg_write / cfg_index / cfg_data write interval_target (0) and spike_limit (1).
//   A baseline item is taken without leaving S_IDLE. An interval item may run the 16-step
//   ratio division in the shared divider. The closing item adds the mean and
//   window-average divisions (PSUM_W + WSUM_W divider steps, 18 + 23 with default
//   parameters) and a ring read-modify-write.
//   One item is worked on at a time; snap_stall is high while it is in flight.
//   The result sits in an output register; a stalled result holds there while the
//   next items are taken, and only a second finished result waits for it.
//   Reset (rst, synchronous) clears the measurement, history fill, window sum, peak
//   and configuration. The history RAM needs no clearing pass: entries are read
//   only after they have been written.
module utilization_window_monitor
  import uwm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256,
  parameter int MAX_INTERVALS = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   snap_valid,
  output logic                   snap_stall,
  input  snapshot_t              snap,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  localparam int PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int WSUM_W = $clog2(HISTORY_DEPTH * FULL_SCALE + 1);
  localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int PSUM_W = $clog2(MAX_INTERVALS * FULL_SCALE + 1);
  localparam int PROD_W = TICK_W + 7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUSY,
    S_SCALE,
    S_RANGE,
    S_RATIO,
    S_ACCUM,
    S_ADVANCE,
    S_MEAN,
    S_MEANW,
    S_RING,
    S_RMW,
    S_AVG,
    S_AVGW,
    S_EMIT
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0]  interval_target;
  logic [PERCENT_W-1:0] spike_limit;

  logic [TICK_W-1:0]    prev_total;
  logic [TICK_W-1:0]    prev_idle;
  logic [TICK_W-1:0]    delta_total;
  logic [TICK_W-1:0]    delta_idle;
  logic [TICK_W-1:0]    busy_ticks;
  logic [PROD_W-1:0]    prod;
  logic [RATIO_W-1:0]   ratio;
  logic                 ratio_rem_nz;
  logic [CNT_W-1:0]     phase;
  logic [CNT_W-1:0]     accepted_count;
  logic [PSUM_W-1:0]    percent_sum;
  logic [PERCENT_W-1:0] cur_percent;
  logic [PTR_W-1:0]     write_pointer;
  logic [FILL_W-1:0]    fill_count;
  logic [WSUM_W-1:0]    window_sum;
  logic [PERCENT_W-1:0] peak_value;

  logic [CNT_W-1:0]     need;
  logic                 snap_take;
  logic                 out_free;
  logic                 ring_full;
  logic                 over;
  logic                 spike;
  logic [PERCENT_W-1:0] clamped;
  logic [PERCENT_W-1:0] old_entry;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 ram_we;
  logic                 ram_re;
  logic [PERCENT_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_target <= INTERVAL_TARGET_RESET;
      spike_limit     <= SPIKE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INTERVAL_TARGET: interval_target <= cfg_data[SAMPLE_W-1:0];
        REG_SPIKE_LIMIT:     spike_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (interval_target == '0) begin
      need = CNT_W'(1);
    end else if ({1'b0, interval_target} > 4'(MAX_INTERVALS)) begin
      need = CNT_W'(MAX_INTERVALS);
    end else begin
      need = CNT_W'(interval_target);
    end
  end

  assign snap_stall = (state != S_IDLE);
  assign snap_take  = snap_valid && !snap_stall;
  assign out_free   = !result_valid || !result_stall;
  assign ring_full  = (fill_count == FILL_W'(HISTORY_DEPTH));
  assign over       = {1'b0, prod[PROD_W-1:8]} >= delta_total;
  assign spike      = (ratio > {1'b0, spike_limit}) ||
                      ((ratio == {1'b0, spike_limit}) && ratio_rem_nz);
  assign clamped    = (ratio > RATIO_W'(FULL_SCALE)) ? PERCENT_W'(FULL_SCALE)
                                                     : ratio[PERCENT_W-1:0];
  assign old_entry  = ring_full ? ram_rdata : '0;

  always_comb begin
    div_req          = '0;
    div_req.start    = 1'b0;
    div_req.steps    = RATIO_STEPS;
    div_req.divisor  = delta_total;
    div_req.rem_init = {1'b0, prod[PROD_W-1:8]};
    div_req.dividend = {prod[7:0], 8'h00, {(DIV_W - 16){1'b0}}};
    case (state)
      S_RANGE: begin
        div_req.start = !over;
      end
      S_MEAN: begin
        div_req.start    = (accepted_count != '0);
        div_req.steps    = DIV_STEP_W'(PSUM_W);
        div_req.divisor  = DIV_W'(accepted_count);
        div_req.rem_init = '0;
        div_req.dividend = {percent_sum, {(DIV_W - PSUM_W){1'b0}}};
      end
      S_AVG: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_STEP_W'(WSUM_W);
        div_req.divisor  = DIV_W'(fill_count);
        div_req.rem_init = '0;
        div_req.dividend = {window_sum, {(DIV_W - WSUM_W){1'b0}}};
      end
      default: ;
    endcase
  end

  assign ram_re = (state == S_RING) && ring_full;
  assign ram_we = (state == S_RMW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      prev_total     <= '0;
      prev_idle      <= '0;
      phase          <= '0;
      accepted_count <= '0;
      percent_sum    <= '0;
      write_pointer  <= '0;
      fill_count     <= '0;
      window_sum     <= '0;
      peak_value     <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (snap_take) begin
            prev_total  <= snap.total_ticks;
            prev_idle   <= snap.idle_ticks;
            delta_total <= snap.total_ticks - prev_total;
            delta_idle  <= snap.idle_ticks - prev_idle;
            if (phase == '0) begin
              phase <= CNT_W'(1);
            end else begin
              state <= S_BUSY;
            end
          end
        end
        S_BUSY: begin
          busy_ticks <= delta_total - delta_idle;
          if (delta_total[TICK_W-1] || delta_total == '0) begin
            state <= S_ADVANCE;
          end else if (!delta_idle[TICK_W-1] && delta_idle > delta_total) begin
            ratio        <= '0;
            ratio_rem_nz <= 1'b0;
            state        <= S_ACCUM;
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod  <= {1'b0, busy_ticks, 6'b0} + {2'b0, busy_ticks, 5'b0} +
                   {5'b0, busy_ticks, 2'b0};
          state <= S_RANGE;
        end
        S_RANGE: begin
          if (over) begin
            ratio        <= RATIO_SAT;
            ratio_rem_nz <= 1'b0;
            state        <= S_ACCUM;
          end else begin
            state <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (div_rsp.done) begin
            ratio        <= div_rsp.quotient[RATIO_W-1:0];
            ratio_rem_nz <= div_rsp.rem_nz;
            state        <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          // drop a spike once an interval is in
          if (!(spike && accepted_count != '0)) begin
            percent_sum    <= percent_sum + PSUM_W'(clamped);
            accepted_count <= accepted_count + 1'b1;
          end
          state <= S_ADVANCE;
        end
        S_ADVANCE: begin
          if (phase < need) begin
            phase <= phase + 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (accepted_count == '0) begin
            cur_percent <= '0;
            state       <= S_RING;
          end else begin
            state <= S_MEANW;
          end
        end
        S_MEANW: begin
          if (div_rsp.done) begin
            cur_percent <= div_rsp.quotient[PERCENT_W-1:0];
            state       <= S_RING;
          end
        end
        S_RING: begin
          state <= S_RMW;
        end
        S_RMW: begin
          window_sum <= window_sum - WSUM_W'(old_entry) + WSUM_W'(cur_percent);
          if (!ring_full) begin
            fill_count <= fill_count + 1'b1;
          end
          if (write_pointer == PTR_W'(HISTORY_DEPTH - 1)) begin
            write_pointer <= '0;
          end else begin
            write_pointer <= write_pointer + 1'b1;
          end
          if (cur_percent > peak_value) begin
            peak_value <= cur_percent;
          end
          state <= S_AVG;
        end
        S_AVG: begin
          state <= S_AVGW;
        end
        S_AVGW: begin
          if (div_rsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result.current_percent <= cur_percent;
            result.average_percent <= div_rsp.quotient[PERCENT_W-1:0];
            result.peak_percent    <= peak_value;
            result.window_fill     <= FILL_OUT_W'(fill_count);
            result.valid_intervals <= VALID_OUT_W'(accepted_count);
            result_valid           <= 1'b1;
            phase                  <= '0;
            accepted_count         <= '0;
            percent_sum            <= '0;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  uwm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  uwm_ram #(
    .WIDTH (PERCENT_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata (cur_percent),
    .re    (ram_re),
    .raddr (write_pointer),
    .rdata (ram_rdata)
  );

  a_acc_le_phase: assert property (@(posedge clk) disable iff (rst)
    accepted_count <= phase)
    else $error("more intervals accepted than taken");
  a_phase_max: assert property (@(posedge clk) disable iff (rst)
    phase <= CNT_W'(MAX_INTERVALS))
    else $error("phase beyond interval limit");
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill beyond depth");
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_EMIT))
    else $error("result raised outside emit");
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.peak_percent >= result.current_percent)
    else $error("peak below current measurement");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for utilization_window_monitor: directed and random snapshot
// streams, checked item by item against a busy-percent predictor. Depends on uwm_pkg.
module testbench;
  import uwm_pkg::*;

  localparam int HISTORY_DEPTH = 256;
  localparam int SETTLE_CYCLES = 120;
  localparam int QUIET_LIMIT   = 4000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_INTERVAL_TARGET;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   snap_valid = 1'b0;
  logic                   snap_stall;
  snapshot_t              snap = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;

  utilization_window_monitor dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .snap_valid   (snap_valid),
    .snap_stall   (snap_stall),
    .snap         (snap),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  bit [SAMPLE_W-1:0]  cfg_samples = INTERVAL_TARGET_RESET;
  bit [PERCENT_W-1:0] cfg_spike = SPIKE_LIMIT_RESET;
  bit [63:0]          last_total = '0;
  bit [63:0]          last_idle = '0;
  bit [2:0]           meas_phase = '0;
  bit [2:0]           taken = '0;
  bit [17:0]          pct_sum = '0;
  bit [PERCENT_W-1:0] history [HISTORY_DEPTH];
  bit [7:0]           wr_ptr = '0;
  bit [8:0]           fill = '0;
  bit [22:0]          win_sum = '0;
  bit [PERCENT_W-1:0] peak = '0;

  result_t   expected_results[$];
  result_t   want;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        idle_pct = 34;
  int        stall_pct = 34;
  bit [63:0] feed_total = '0;
  bit [63:0] feed_idle = '0;

  function automatic void score_interval(snapshot_t s);
    bit [63:0]  td;
    bit [63:0]  id;
    bit [127:0] prod;
    bit [127:0] quo;
    bit [127:0] rem;
    bit [15:0]  ratio;
    bit         neg_busy;
    td = s.total_ticks - last_total;
    id = s.idle_ticks - last_idle;
    if (td[63] || td == 0) return;
    neg_busy = !id[63] && (id > td);
    ratio = '0;
    rem = '0;
    if (!neg_busy) begin
      prod = 128'(td - id) * 128'(FULL_SCALE);
      quo = prod / 128'(td);
      rem = prod % 128'(td);
      ratio = (quo > 128'hFFFF) ? 16'hFFFF : quo[15:0];
    end
    if (!neg_busy && taken != 0 && (ratio > cfg_spike || (ratio == cfg_spike && rem != 0)))
      return;
    if (ratio > FULL_SCALE) ratio = 16'(FULL_SCALE);
    pct_sum += 18'(ratio);
    taken++;
  endfunction

  function automatic void predict_snapshot(snapshot_t s);
    bit [2:0]           need;
    bit [PERCENT_W-1:0] cur;
    result_t            r;
    need = (cfg_samples == 0) ? 3'd1 : cfg_samples;
    if (meas_phase == 0) begin
      last_total = s.total_ticks;
      last_idle = s.idle_ticks;
      meas_phase = 3'd1;
      return;
    end
    score_interval(s);
    last_total = s.total_ticks;
    last_idle = s.idle_ticks;
    if (meas_phase < need) begin
      meas_phase++;
      return;
    end
    cur = (taken != 0) ? PERCENT_W'(pct_sum / taken) : '0;
    if (fill == 9'(HISTORY_DEPTH)) win_sum -= 23'(history[wr_ptr]);
    else fill++;
    history[wr_ptr] = cur;
    win_sum += 23'(cur);
    wr_ptr++;
    if (cur > peak) peak = cur;
    r.current_percent = cur;
    r.average_percent = PERCENT_W'(win_sum / fill);
    r.peak_percent = peak;
    r.window_fill = fill;
    r.valid_intervals = taken;
    expected_results.push_back(r);
    meas_phase = '0;
    taken = '0;
    pct_sum = '0;
  endfunction

  function automatic snapshot_t next_snapshot();
    snapshot_t s;
    bit [63:0] dt;
    bit [63:0] di;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 6) begin
      s = {$urandom, $urandom, $urandom, $urandom};
      return s;
    end
    case ($urandom_range(3))
      0: dt = 64'($urandom_range(1, 64));
      1: dt = 64'($urandom_range(1, 1000000));
      2: dt = {16'h0, 16'($urandom), 32'($urandom)};
      default: dt = 64'($urandom_range(100, 5000));
    endcase
    di = (dt * 64'($urandom_range(0, 256))) >> 8;
    if (roll < 9) dt = '0;
    else if (roll < 12) dt = -dt;
    else if (roll < 15) di = dt + 64'($urandom_range(1, 1000));
    else if (roll < 18) di = -64'($urandom_range(1, 1000));
    else if (roll < 30) di = (dt * 64'($urandom_range(0, 20))) >> 8;
    s.total_ticks = feed_total + dt;
    s.idle_ticks = feed_idle + di;
    return s;
  endfunction

  task automatic send_snapshot(input bit [63:0] total, input bit [63:0] idle);
    snapshot_t item;
    item.total_ticks = total;
    item.idle_ticks = idle;
    while ($urandom_range(99) < idle_pct) begin
      snap_valid <= 1'b0;
      @(posedge clk);
    end
    snap_valid <= 1'b1;
    snap <= item;
    @(posedge clk);
    while (snap_stall !== 1'b0) @(posedge clk);
    feed_total = total;
    feed_idle = idle;
    predict_snapshot(item);
  endtask

  task automatic drain_results();
    snap_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input bit [SAMPLE_W-1:0] samples,
                                input bit [PERCENT_W-1:0] limit);
    cfg_write <= 1'b1;
    cfg_index <= REG_INTERVAL_TARGET;
    cfg_data <= CFG_DATA_W'(samples);
    @(posedge clk);
    cfg_index <= REG_SPIKE_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_samples = samples;
    cfg_spike = limit;
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  task automatic check_result(input result_t got);
    if (expected_results.size() == 0) begin
      $display("%0t: result expected none got %p", $time, got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      compare_field("current_percent", 32'(want.current_percent), 32'(got.current_percent));
      compare_field("average_percent", 32'(want.average_percent), 32'(got.average_percent));
      compare_field("peak_percent", 32'(want.peak_percent), 32'(got.peak_percent));
      compare_field("window_fill", 32'(want.window_fill), 32'(got.window_fill));
      compare_field("valid_intervals", 32'(want.valid_intervals), 32'(got.valid_intervals));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) check_result(result);
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (snap_valid && snap_stall === 1'b0) || (result_valid === 1'b1 && !result_stall))
      quiet_cycles <= 0;
    else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic test_defaults_after_reset();
    send_snapshot(64'd0, 64'd0);
    send_snapshot(64'd25600, 64'd0);
    send_snapshot(64'd51200, 64'd1280);
    send_snapshot(64'd102400, 64'd3839);
  endtask

  task automatic test_interval_edge_cases();
    drain_results();
    apply_settings(3'd1, 15'h7FFF);
    send_snapshot(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_snapshot(64'd9, 64'd4);
    send_snapshot(64'd100, 64'd500);
    send_snapshot(64'd110, 64'd495);
    send_snapshot(64'd1000, 64'd0);
    send_snapshot(64'd1000, 64'd0);
    send_snapshot(64'd5000, 64'd0);
    send_snapshot(64'h8000_0000_0000_1388, 64'd0);
    send_snapshot(64'd0, 64'd0);
    send_snapshot(64'd10, 64'd20);
    send_snapshot(64'd0, 64'd0);
    send_snapshot(64'h4000_0000_0000_0000, 64'd0);
  endtask

  task automatic test_interval_target_lowered();
    drain_results();
    apply_settings(3'd7, 15'd24320);
    send_snapshot(64'd0, 64'd0);
    send_snapshot(64'd1000, 64'd500);
    send_snapshot(64'd2000, 64'd600);
    send_snapshot(64'd3000, 64'd1400);
    drain_results();
    apply_settings(3'd2, 15'd24320);
    send_snapshot(64'd4000, 64'd1450);
  endtask

  task automatic run_traffic_phase(input bit [SAMPLE_W-1:0] samples,
                                   input bit [PERCENT_W-1:0] limit, input int count,
                                   input int idling);
    snapshot_t item;
    drain_results();
    apply_settings(samples, limit);
    idle_pct = idling;
    stall_pct = idling;
    repeat (count) begin
      item = next_snapshot();
      send_snapshot(item.total_ticks, item.idle_ticks);
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(3'd1, 15'd0, 200, 34);
    run_traffic_phase(3'd0, 15'h7FFF, 150, 34);
    run_traffic_phase(3'd7, 15'd25600, 120, 34);
    run_traffic_phase(3'd3, 15'd24320, 100, 34);
    run_traffic_phase(3'd1, 15'($urandom_range(20000, 25600)), 200, 0);
    run_traffic_phase(3'($urandom_range(1, 7)), 15'($urandom_range(0, 25600)), 130, 34);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults_after_reset();
    test_interval_edge_cases();
    test_interval_target_lowered();
    test_random_traffic();
    drain_results();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
